// File: rtl/pee_pkg.sv
package pee_pkg;

	localparam int MaxTokens = 256;
	localparam int IdxW = $clog2(MaxTokens);
	localparam int CntW = IdxW + 1;
	localparam int CapW = 9;

	localparam logic [2:0] KIND_NUM = 3'd0;
	localparam logic [2:0] KIND_ADD = 3'd1;
	localparam logic [2:0] KIND_SUB = 3'd2;
	localparam logic [2:0] KIND_MUL = 3'd3;
	localparam logic [2:0] KIND_DIV = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_SHORT   = 3'd1;
	localparam logic [2:0] ST_INVALID = 3'd2;
	localparam logic [2:0] ST_DIVZERO = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	typedef struct packed {
		logic       store;     // write the incoming token
		logic       start;     // begin the evaluation pass
		logic       tok_rd;    // read token at index
		logic       exec;      // act on the fetched token
		logic       pop_a;     // read top into operand a
		logic       pop_b;     // read top into operand b
		logic       do_op;     // compute and push
		logic       div_go;    // start the divider
		logic       finish;    // read the answer from the stack top
		logic       clear;     // drop the result after delivery
	} cmd_t;

	typedef struct packed {
		logic       tokens_left;
		logic       is_num;
		logic       is_div;
		logic       is_inv;
		logic       short_a;
		logic       short_b;
		logic       div_done;
	} sts_t;

endpackage

// File: rtl/pee_if.sv
interface pee_tok_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic signed [31:0] value;
	logic        last;
	modport source (output valid, kind, value, last, input ready);
	modport sink (input valid, kind, value, last, output ready);
endinterface

interface pee_res_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] answer;
	logic [2:0]  status;
	modport source (output valid, answer, status, input ready);
	modport sink (input valid, answer, status, output ready);
endinterface

// File: rtl/pee_div.sv
module pee_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] quo
);
	logic [31:0] rem_q, quo_q, den_q;
	logic [5:0]  cnt_q;
	logic        busy_q, neg_q, done_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	assign shifted = {rem_q[30:0], quo_q[31]};
	assign trial = {1'b0, shifted} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division, one quotient bit a cycle on magnitudes
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			quo_q <= a[31] ? (32'd0 - a) : a;
			den_q <= b[31] ? (32'd0 - b) : b;
			neg_q <= a[31] ^ b[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = neg_q ? (32'd0 - quo_q) : quo_q;
endmodule

// File: rtl/pee_datapath.sv
module pee_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  pee_pkg::cmd_t    cmd,
	input  logic [8:0]       capacity,
	input  logic [2:0]       kind,
	input  logic [31:0]      value,
	output pee_pkg::sts_t    sts,
	output logic [31:0]      answer,
	output logic             empty
);
	logic [2:0]  kind_mem [pee_pkg::MaxTokens];
	logic [31:0] val_mem [pee_pkg::MaxTokens];
	logic [31:0] stk_mem [pee_pkg::MaxTokens];
	logic [pee_pkg::CntW-1:0] cnt_q, idx_q, sp_q, cap_eff;
	logic [2:0]  tk_q;
	logic [31:0] tv_q, a_q, b_q, stk_rd_q, res;
	logic        a_sel_q;
	logic        b_sel_q;
	logic        empty_q;
	logic        div_done;
	logic [31:0] quo;
	logic [pee_pkg::CntW-1:0] sp_m1;

	assign cap_eff = (capacity > 9'(pee_pkg::MaxTokens)) ?
		pee_pkg::CntW'(pee_pkg::MaxTokens) : pee_pkg::CntW'(capacity);
	assign sp_m1 = sp_q - 1'b1;

	pee_div u_div (
		.clk(clk), .arst_n(arst_n), .go(cmd.div_go),
		.a(a_q), .b(b_q), .done(div_done), .quo(quo)
	);

	always_comb begin
		unique case (tk_q)
			pee_pkg::KIND_ADD: res = a_q + b_q;
			pee_pkg::KIND_SUB: res = a_q - b_q;
			pee_pkg::KIND_MUL: res = a_q * b_q;
			default:           res = quo;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.store && cnt_q < cap_eff)
			kind_mem[cnt_q[pee_pkg::IdxW-1:0]] <= kind;
		if (cmd.store && cnt_q < cap_eff)
			val_mem[cnt_q[pee_pkg::IdxW-1:0]] <= value;
		if (cmd.tok_rd) begin
			tk_q <= kind_mem[idx_q[pee_pkg::IdxW-1:0] - 1'b1];
			tv_q <= val_mem[idx_q[pee_pkg::IdxW-1:0] - 1'b1];
		end
		if (cmd.pop_a || cmd.pop_b || cmd.finish)
			stk_rd_q <= stk_mem[sp_m1[pee_pkg::IdxW-1:0]];
		if (a_sel_q) a_q <= stk_rd_q;
		if (b_sel_q) b_q <= stk_rd_q;
		if (cmd.exec && tk_q == pee_pkg::KIND_NUM && sp_q < cap_eff)
			stk_mem[sp_q[pee_pkg::IdxW-1:0]] <= tv_q;
		if (cmd.do_op && sp_q < cap_eff)
			stk_mem[sp_q[pee_pkg::IdxW-1:0]] <= res;
	end

	// Stack read data lands in the cycle after the pop; latch it into a or b then
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
			sp_q <= '0;
			a_sel_q <= 1'b0;
			b_sel_q <= 1'b0;
			empty_q <= 1'b0;
		end else begin
			a_sel_q <= cmd.pop_a && sp_q != '0;
			b_sel_q <= cmd.pop_b && sp_q != '0;
			if (cmd.store && cnt_q < cap_eff) cnt_q <= cnt_q + 1'b1;
			if (cmd.start) begin
				idx_q <= (cmd.store && cnt_q < cap_eff) ? cnt_q + 1'b1 : cnt_q;
				sp_q <= '0;
			end
			if (cmd.tok_rd) idx_q <= idx_q - 1'b1;
			if (cmd.exec && tk_q == pee_pkg::KIND_NUM && sp_q < cap_eff)
				sp_q <= sp_q + 1'b1;
			if ((cmd.pop_a || cmd.pop_b) && sp_q != '0) sp_q <= sp_m1;
			if (cmd.do_op && sp_q < cap_eff) sp_q <= sp_q + 1'b1;
			if (cmd.finish) empty_q <= (sp_q == '0);
			if (cmd.clear) begin
				cnt_q <= '0;
				sp_q <= '0;
			end
		end
	end

	assign sts.tokens_left = idx_q != '0;
	assign sts.is_num = tk_q == pee_pkg::KIND_NUM;
	assign sts.is_div = tk_q == pee_pkg::KIND_DIV;
	assign sts.is_inv = tk_q > pee_pkg::KIND_DIV;
	assign sts.short_a = sp_q == '0;
	assign sts.short_b = sp_q == '0;
	assign sts.div_done = div_done;
	assign answer = stk_rd_q;
	assign empty = empty_q;
endmodule

// File: rtl/pee_ctrl.sv
module pee_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             in_last,
	input  pee_pkg::sts_t    sts,
	input  logic [31:0]      dp_answer,
	input  logic             dp_empty,
	output pee_pkg::cmd_t    cmd,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      answer,
	output logic [2:0]       status
);
	typedef enum logic [9:0] {
		S_LOAD  = 10'b0000000001,
		S_FETCH = 10'b0000000010,
		S_EXEC  = 10'b0000000100,
		S_POPA  = 10'b0000001000,
		S_POPB  = 10'b0000010000,
		S_OP    = 10'b0000100000,
		S_DIV   = 10'b0001000000,
		S_FIN   = 10'b0010000000,
		S_FIN2  = 10'b0100000000,
		S_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [31:0] ans_q;
	logic [2:0]  st_q;
	logic [31:0] b_seen_q;

	always_comb begin
		cmd = '0;
		cmd.store = in_fire;
		cmd.start = in_fire && in_last;
		cmd.tok_rd = state_q == S_FETCH && sts.tokens_left;
		cmd.exec = state_q == S_EXEC;
		cmd.pop_a = state_q == S_EXEC && !sts.is_num;
		cmd.pop_b = state_q == S_POPA;
		cmd.finish = state_q == S_FETCH && !sts.tokens_left;
		cmd.div_go = state_q == S_OP && sts.is_div && b_seen_q != '0;
		cmd.do_op = (state_q == S_OP && !sts.is_div && !sts.is_inv) ||
			(state_q == S_DIV && sts.div_done);
		cmd.clear = state_q == S_OUT && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			st_q <= pee_pkg::ST_OK;
			ans_q <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: if (in_fire && in_last) state_q <= S_FETCH;
				S_FETCH: state_q <= sts.tokens_left ? S_EXEC : S_FIN;
				S_EXEC: begin
					if (sts.is_num) state_q <= S_FETCH;
					else if (sts.short_a) begin
						st_q <= pee_pkg::ST_SHORT;
						state_q <= S_OUT;
					end else state_q <= S_POPA;
				end
				S_POPA: if (sts.short_b) begin
					st_q <= pee_pkg::ST_SHORT;
					state_q <= S_OUT;
				end else state_q <= S_POPB;
				S_POPB: state_q <= S_OP;
				S_OP: begin
					if (sts.is_inv) begin
						st_q <= pee_pkg::ST_INVALID;
						state_q <= S_OUT;
					end else if (sts.is_div && b_seen_q == '0) begin
						st_q <= pee_pkg::ST_DIVZERO;
						state_q <= S_OUT;
					end else if (sts.is_div) state_q <= S_DIV;
					else state_q <= S_FETCH;
				end
				S_DIV: if (sts.div_done) state_q <= S_FETCH;
				S_FIN: state_q <= S_FIN2;
				S_FIN2: begin
					st_q <= dp_empty ? pee_pkg::ST_EMPTY : pee_pkg::ST_OK;
					ans_q <= dp_answer;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_LOAD;
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Track operand b: stack read data arrives the cycle after the pop
	always_ff @(posedge clk) begin
		if (state_q == S_POPB) b_seen_q <= dp_answer;
	end

	assign in_ready = state_q == S_LOAD;
	assign out_valid = state_q == S_OUT;
	assign status = st_q;
	assign answer = (st_q == pee_pkg::ST_OK) ? ans_q : 32'd0;
endmodule

// File: rtl/prefix_expression_evaluator_top.sv
// Prefix expression evaluator: tokens load one item per cycle into a token RAM.
// After the last item the stored tokens are walked last to first (a divide makes one
// quotient bit per cycle); operators pop two operands and push one; an error ends early.
// Intake holds during evaluation and until the result item is taken.
// Reset (arst_n low) empties the token count and the stack and sets capacity 256;
// the token and stack memories are not cleared.
module prefix_expression_evaluator_top (
	input  logic       clk,
	input  logic       arst_n,
	pee_tok_if.sink    tok,
	pee_res_if.source  res,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata
);
	pee_pkg::cmd_t cmd;
	pee_pkg::sts_t sts;
	logic [8:0]  capacity_q;
	logic [31:0] dp_answer;
	logic        dp_empty;
	logic        in_fire;

	// Hold the capacity register; the user must write it only while idle, which the block itself does not enforce
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) capacity_q <= 9'd256;
		else if (cfg_we) capacity_q <= cfg_wdata;
	end

	assign in_fire = tok.valid && tok.ready;

	pee_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .capacity(capacity_q),
		.kind(tok.kind), .value(tok.value), .sts(sts),
		.answer(dp_answer), .empty(dp_empty)
	);

	pee_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(tok.last),
		.sts(sts), .dp_answer(dp_answer), .dp_empty(dp_empty),
		.cmd(cmd), .in_ready(tok.ready),
		.out_valid(res.valid), .out_ready(res.ready),
		.answer(res.answer), .status(res.status)
	);
endmodule

// File: rtl/pee_checker.sv
module pee_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       tok_valid,
	input logic       tok_ready,
	input logic       tok_last,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] res_status,
	input logic [31:0] res_answer
);
	a_no_intake_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !tok_ready) else $error("intake open while result pending");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_status != pee_pkg::ST_OK) |-> res_answer == 32'd0)
		else $error("nonzero answer on error");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_status <= pee_pkg::ST_EMPTY) else $error("bad status");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid && $stable(res_status) &&
		$stable(res_answer))
		else $error("result dropped");
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(tok_valid && tok_ready && tok_last) |=> !tok_ready)
		else $error("intake open after last item");
endmodule

bind prefix_expression_evaluator_top pee_checker u_chk (
	.clk(clk), .arst_n(arst_n), .tok_valid(tok.valid), .tok_ready(tok.ready),
	.tok_last(tok.last), .res_valid(res.valid), .res_ready(res.ready),
	.res_status(res.status), .res_answer(res.answer)
);

// File: dv/expr_checker.sv
module expr_checker (
	input  logic       clk,
	input  logic       arst_n,
	pee_tok_if         tok,
	pee_res_if         res,
	input  logic       cfg_we,
	input  logic [8:0] cfg_wdata,
	output int         errors,
	output int         pending,
	output int         answers_seen
);

	typedef struct packed {
		logic signed [31:0] answer;
		logic [2:0]         status;
	} outcome_t;

	logic [8:0]  capacity;
	logic [2:0]  tk_kind [pee_pkg::MaxTokens];
	logic [31:0] tk_val [pee_pkg::MaxTokens];
	int          tk_count;
	outcome_t    outcome_q[$];
	int          err_acc;
	int          seen_acc;

	function automatic int eff_cap();
		return (capacity > pee_pkg::MaxTokens) ? pee_pkg::MaxTokens : int'(capacity);
	endfunction

	function automatic logic [31:0] div_trunc(logic [31:0] a, logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	// Walk the stored tokens right to left; the first error ends the walk.
	function automatic outcome_t evaluate_tokens();
		logic [31:0] stk [pee_pkg::MaxTokens];
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] r;
		int          sp;
		int          lim;
		outcome_t    o;
		sp = 0;
		lim = eff_cap();
		o.answer = '0;
		for (int i = tk_count - 1; i >= 0; i--) begin
			if (tk_kind[i] == pee_pkg::KIND_NUM) begin
				if (sp < lim) begin
					stk[sp] = tk_val[i];
					sp++;
				end
				continue;
			end
			if (sp < 2) begin
				o.status = pee_pkg::ST_SHORT;
				return o;
			end
			a = stk[sp - 1];
			b = stk[sp - 2];
			sp -= 2;
			case (tk_kind[i])
				pee_pkg::KIND_ADD: r = a + b;
				pee_pkg::KIND_SUB: r = a - b;
				pee_pkg::KIND_MUL: r = a * b;
				pee_pkg::KIND_DIV: begin
					if (b == 0) begin
						o.status = pee_pkg::ST_DIVZERO;
						return o;
					end
					r = div_trunc(a, b);
				end
				default: begin
					o.status = pee_pkg::ST_INVALID;
					return o;
				end
			endcase
			if (sp < lim) begin
				stk[sp] = r;
				sp++;
			end
		end
		if (sp == 0) begin
			o.status = pee_pkg::ST_EMPTY;
			return o;
		end
		o.answer = stk[sp - 1];
		o.status = pee_pkg::ST_OK;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity <= 9'd256;
			tk_count = 0;
			outcome_q.delete();
			err_acc = 0;
			seen_acc = 0;
			errors <= 0;
			pending <= 0;
			answers_seen <= 0;
		end else begin
			if (cfg_we)
				capacity <= cfg_wdata;
			if (res.valid && res.ready) begin
				seen_acc++;
				if (outcome_q.size() == 0) begin
					err_acc++;
					$display("%0t: unexpected result answer=%0d status=%0d",
						$time, res.answer, res.status);
				end else begin
					outcome_t want;
					want = outcome_q.pop_front();
					if (want.answer !== res.answer || want.status !== res.status) begin
						err_acc++;
						$display("%0t: mismatch expected answer=%0d status=%0d,",
							$time, want.answer, want.status);
						$display("%0t:          got answer=%0d status=%0d",
							$time, res.answer, res.status);
					end
				end
			end
			if (tok.valid && tok.ready) begin
				if (tk_count < eff_cap()) begin
					tk_kind[tk_count] = tok.kind;
					tk_val[tk_count] = tok.value;
					tk_count++;
				end
				if (tok.last) begin
					outcome_q.push_back(evaluate_tokens());
					tk_count = 0;
				end
			end
			errors <= err_acc;
			pending <= outcome_q.size();
			answers_seen <= seen_acc;
		end
	end

endmodule

// File: dv/tb.sv
module tb;

	// Any kind above divide is an unrecognised symbol.
	localparam logic [2:0] KIND_SYM = 3'd5;
	localparam logic [31:0] INT_MIN = 32'h8000_0000;
	localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
	localparam int TOTAL_ITEMS = 1150;
	localparam int QUIET_AFTER = 1000;
	localparam int CYCLE_LIMIT = 3_000_000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] value;
	} token_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [8:0] cfg_wdata = '0;
	logic       quiet = 1'b0;
	int         stall_left;
	int         cycles = 0;
	int         items_sent = 0;
	int         cap_writes = 0;
	int         errors;
	int         pending;
	int         answers_seen;
	token_t     expr_q[$];

	pee_tok_if tok ();
	pee_res_if res ();

	initial begin
		tok.valid = 1'b0;
		tok.kind = '0;
		tok.value = '0;
		tok.last = 1'b0;
		res.ready = 1'b0;
	end

	always #5 clk = ~clk;

	prefix_expression_evaluator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tok      (tok.sink),
		.res      (res.source),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	expr_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok         (tok),
		.res         (res),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.errors      (errors),
		.pending     (pending),
		.answers_seen(answers_seen)
	);

	// Hard stop: no correct run comes near this many cycles.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout with %0d results outstanding", pending);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: stall in random bursts, never once quiet.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			res.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	// Present one item and hold it until the block takes it. Valid stays
	// high across back-to-back items; a gap lowers it for a random burst.
	task automatic send_item(logic [2:0] kind, logic [31:0] value, logic last);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			tok.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		tok.valid <= 1'b1;
		tok.kind <= kind;
		tok.value <= value;
		tok.last <= last;
		@(posedge clk);
		while (!tok.ready) @(posedge clk);
		items_sent++;
	endtask

	// Send the queued expression, marking its final token as last.
	task automatic send_expr();
		for (int i = 0; i < expr_q.size(); i++)
			send_item(expr_q[i].kind, expr_q[i].value, i == expr_q.size() - 1);
		expr_q.delete();
	endtask

	// Hold the sender until every outstanding result has been taken, then
	// let the evaluator settle before anything else happens.
	task automatic drain();
		tok.valid <= 1'b0;
		@(posedge clk);
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_capacity(logic [8:0] cap);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_writes++;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'd1;
			2: return 32'hffff_ffff;
			3: return INT_MIN;
			4: return INT_MAX;
			5: return $urandom_range(0, 20) - 10;
			default: return $urandom;
		endcase
	endfunction

	// Build a prefix expression of about budget tokens, well-formed but for a rare unrecognised symbol.
	function automatic void build_expr(int budget);
		int left;
		if (budget <= 2 || $urandom_range(0, 9) < 3) begin
			expr_q.push_back({pee_pkg::KIND_NUM, pick_value()});
			return;
		end
		if ($urandom_range(0, 49) == 0)
			expr_q.push_back({3'($urandom_range(KIND_SYM, 7)), 32'($urandom)});
		else
			expr_q.push_back({3'($urandom_range(pee_pkg::KIND_ADD, pee_pkg::KIND_DIV)),
				32'($urandom)});
		left = $urandom_range(1, budget - 2);
		build_expr(left);
		build_expr(budget - 1 - left);
	endfunction

	function automatic void push_tok(logic [2:0] kind, logic [31:0] value);
		expr_q.push_back({kind, value});
	endfunction

	initial begin
		int n;
		int mode;
		int exprs;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: each operator and the corner results.
		push_tok(pee_pkg::KIND_ADD, 0);
		push_tok(pee_pkg::KIND_NUM, 3); push_tok(pee_pkg::KIND_NUM, 4);
		send_expr();
		push_tok(pee_pkg::KIND_SUB, INT_MAX);
		push_tok(pee_pkg::KIND_NUM, INT_MIN); push_tok(pee_pkg::KIND_NUM, 1);
		send_expr();
		push_tok(pee_pkg::KIND_MUL, 0);
		push_tok(pee_pkg::KIND_NUM, INT_MAX); push_tok(pee_pkg::KIND_NUM, 2);
		send_expr();
		// Division truncates toward zero.
		push_tok(pee_pkg::KIND_DIV, 0);
		push_tok(pee_pkg::KIND_NUM, -7); push_tok(pee_pkg::KIND_NUM, 2);
		send_expr();
		// Minimum over minus one wraps.
		push_tok(pee_pkg::KIND_DIV, 0);
		push_tok(pee_pkg::KIND_NUM, INT_MIN); push_tok(pee_pkg::KIND_NUM, -1);
		send_expr();
		// Zero divisor.
		push_tok(pee_pkg::KIND_DIV, 0);
		push_tok(pee_pkg::KIND_NUM, 5); push_tok(pee_pkg::KIND_NUM, 0);
		send_expr();
		// One operand short, then unrecognised symbols after two good pops.
		push_tok(pee_pkg::KIND_ADD, 0); push_tok(pee_pkg::KIND_NUM, 1);
		send_expr();
		push_tok(KIND_SYM, 0);
		push_tok(pee_pkg::KIND_NUM, 1); push_tok(pee_pkg::KIND_NUM, 2);
		send_expr();
		push_tok(3'd7, 0);
		push_tok(pee_pkg::KIND_NUM, 1); push_tok(pee_pkg::KIND_NUM, 2);
		send_expr();
		// Extra operands: the top of the stack is the answer.
		push_tok(pee_pkg::KIND_NUM, 1); push_tok(pee_pkg::KIND_NUM, 2);
		send_expr();

		// Zero capacity: nothing is stored, so the stack ends empty.
		write_capacity(9'd0);
		push_tok(pee_pkg::KIND_NUM, 9);
		send_expr();
		// Capacity one keeps only the operator.
		write_capacity(9'd1);
		push_tok(pee_pkg::KIND_ADD, 0);
		push_tok(pee_pkg::KIND_NUM, 1); push_tok(pee_pkg::KIND_NUM, 2);
		send_expr();
		// Tokens past capacity drop, but a dropped last still starts evaluation.
		write_capacity(9'd2);
		push_tok(pee_pkg::KIND_NUM, 5); push_tok(pee_pkg::KIND_NUM, 6);
		push_tok(pee_pkg::KIND_NUM, 7);
		send_expr();

		// Shrink capacity mid-expression: all stored tokens are walked, and a
		// push onto the one-deep stack drops.
		write_capacity(9'd256);
		send_item(pee_pkg::KIND_ADD, 0, 1'b0);
		send_item(pee_pkg::KIND_NUM, 1, 1'b0);
		send_item(pee_pkg::KIND_NUM, 2, 1'b0);
		write_capacity(9'd1);
		send_item(pee_pkg::KIND_NUM, 3, 1'b1);
		write_capacity(9'd511);
		drain();

		// Random: mostly well-formed expressions, some noise and broken ones.
		exprs = 0;
		while (items_sent < TOTAL_ITEMS) begin
			if (items_sent >= QUIET_AFTER)
				quiet <= 1'b1;
			exprs++;
			if (exprs % 30 == 0) begin
				case ($urandom_range(0, 7))
					0: write_capacity(9'd1);
					1: write_capacity(9'd3);
					2: write_capacity(9'd8);
					3: write_capacity(9'd511);
					4: write_capacity(9'($urandom_range(1, 511)));
					default: write_capacity(9'd256);
				endcase
			end
			if (exprs == 20)
				drain();
			mode = $urandom_range(0, 9);
			if (mode == 0) begin
				n = $urandom_range(1, 8);
				repeat (n) push_tok(3'($urandom_range(0, 7)), pick_value());
			end else begin
				if ($urandom_range(0, 39) == 0)
					build_expr($urandom_range(200, 300));
				else
					build_expr($urandom_range(1, 25));
				// Break it: drop one token.
				if (mode == 1 && expr_q.size() > 1)
					expr_q.delete($urandom_range(0, expr_q.size() - 1));
			end
			send_expr();
		end

		drain();
		$display("ran %0d items, %0d results, %0d capacity settings",
			items_sent, answers_seen, cap_writes);
		$display("mixed operators, corner values, short stacks and over-capacity expressions");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/pee_pkg.sv
rtl/pee_if.sv
rtl/pee_div.sv
rtl/pee_datapath.sv
rtl/pee_ctrl.sv
rtl/prefix_expression_evaluator_top.sv
rtl/pee_checker.sv
dv/expr_checker.sv
dv/tb.sv
